// ===== src/ble_pkg.sv =====
// Package for the bounded list engine: operation and status codes, cell
// control modes, port widths and default sizes.
// No dependencies.
package ble_pkg;

    // Default sizes for the top-level parameters
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int OP_W     = 4;
    localparam int IN_VAL_W = 32;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int ST_W     = 2;
    localparam int RD_VAL_W = 32;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSHBACK    = 4'd0,
        OP_PUSHFRONT   = 4'd1,
        OP_POPFRONT    = 4'd2,
        OP_POPBACK     = 4'd3,
        OP_INSERT      = 4'd4,
        OP_DROPLAST    = 4'd5,
        OP_DROPSECOND  = 4'd6,
        OP_APPENDLEN   = 4'd7,
        OP_APPENDRANGE = 4'd8,
        OP_BEFORELAST  = 4'd9,
        OP_READ        = 4'd10
    } t_op;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_SHORT = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // What every cell of the row does at a clock edge
    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_INSERT = 2'd1,
        CM_REMOVE = 2'd2,
        CM_RANGE  = 2'd3
    } t_cell_mode;

endpackage

// ===== src/ble_cell.sv =====
// One storage cell of the list row: holds one element and reloads it from
// its left or right neighbor, the broadcast value, or its own range rank.
// Depends on ble_pkg.
module ble_cell
    import ble_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int CELL_INDEX  = 0
) (
    input  logic                          i_clk,
    input  t_cell_mode                    i_mode,
    input  logic [$clog2(CAPACITY)-1:0]   i_at,
    input  logic [$clog2(CAPACITY+1)-1:0] i_fill,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic signed [VALUE_WIDTH-1:0] i_left,
    input  logic signed [VALUE_WIDTH-1:0] i_right,
    output logic signed [VALUE_WIDTH-1:0] o_q
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic [FW-1:0]                 w_rank;

    // Position of this cell within an appended range, counted from 1
    assign w_rank = FW'(CELL_INDEX) - i_fill + FW'(1);

    // Pick the next element for this cell
    always_comb begin
        n_value = r_value;
        case (i_mode)
            CM_INSERT: begin
                if (AW'(CELL_INDEX) == i_at) begin
                    n_value = i_value;
                end else if (AW'(CELL_INDEX) > i_at) begin
                    n_value = i_left;
                end
            end
            CM_REMOVE: begin
                if (AW'(CELL_INDEX) >= i_at) begin
                    n_value = i_right;
                end
            end
            CM_RANGE: begin
                if (FW'(CELL_INDEX) >= i_fill) begin
                    n_value = VALUE_WIDTH'(w_rank);
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // Hold the element
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_q = r_value;

endmodule

// ===== src/ble_ctrl.sv =====
// Operation decoder and fill counter of the list engine: turns one operation
// into the broadcast command for the cell row, the next length and a status.
// Depends on ble_pkg.
module ble_ctrl
    import ble_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [OP_W-1:0]               i_op,
    input  logic signed [IN_VAL_W-1:0]    i_item_value,
    input  logic [POS_W-1:0]              i_position,
    input  logic [POS_W-1:0]              i_count,
    output t_cell_mode                    o_mode,
    output logic [$clog2(CAPACITY)-1:0]   o_at,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic [$clog2(CAPACITY+1)-1:0] o_fill,
    output logic [$clog2(CAPACITY+1)-1:0] o_next_fill,
    output t_status                       o_status,
    output logic                          o_rd_hit
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > POS_W) ? FW : POS_W;

    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_cnt;
    logic [CW-1:0] w_fill;
    logic [CW-1:0] w_room;
    logic          w_full;
    t_cell_mode    w_mode;

    assign w_pos  = CW'(i_position);
    assign w_cnt  = CW'(i_count);
    assign w_fill = CW'(r_fill);
    assign w_room = CW'(CAPACITY) - w_fill;
    assign w_full = (w_fill == CW'(CAPACITY));

    // Decode the operation
    always_comb begin
        w_mode   = CM_HOLD;
        o_at     = AW'(r_fill);
        o_value  = VALUE_WIDTH'(i_item_value);
        n_fill   = r_fill;
        o_status = ST_DONE;
        o_rd_hit = 1'b0;
        case (t_op'(i_op))
            OP_PUSHBACK, OP_PUSHFRONT, OP_INSERT, OP_APPENDLEN: begin
                if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    w_mode = CM_INSERT;
                    n_fill = r_fill + FW'(1);
                    if (t_op'(i_op) == OP_PUSHFRONT) begin
                        o_at = '0;
                    end else if (t_op'(i_op) == OP_INSERT && w_pos < w_fill) begin
                        o_at = AW'(w_pos);
                    end
                    if (t_op'(i_op) == OP_APPENDLEN) begin
                        o_value = VALUE_WIDTH'(r_fill);
                    end
                end
            end
            OP_POPFRONT, OP_POPBACK: begin
                if (r_fill == '0) begin
                    o_status = ST_SHORT;
                end else begin
                    n_fill = r_fill - FW'(1);
                    if (t_op'(i_op) == OP_POPFRONT) begin
                        w_mode = CM_REMOVE;
                        o_at   = '0;
                    end
                end
            end
            OP_DROPLAST: begin
                if (w_cnt >= w_fill) begin
                    n_fill = '0;
                end else begin
                    n_fill = FW'(w_fill - w_cnt);
                end
            end
            OP_DROPSECOND: begin
                if (r_fill <= FW'(1)) begin
                    o_status = ST_SHORT;
                end else begin
                    w_mode = CM_REMOVE;
                    o_at   = AW'(1);
                    n_fill = r_fill - FW'(1);
                end
            end
            OP_APPENDRANGE: begin
                w_mode = CM_RANGE;
                if (w_cnt > w_room) begin
                    o_status = ST_FULL;
                    n_fill   = FW'(CAPACITY);
                end else begin
                    n_fill = FW'(w_fill + w_cnt);
                end
            end
            OP_BEFORELAST: begin
                if (r_fill <= FW'(1)) begin
                    o_status = ST_SHORT;
                end else if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    w_mode = CM_INSERT;
                    o_at   = AW'(r_fill - FW'(1));
                    n_fill = r_fill + FW'(1);
                end
            end
            OP_READ: begin
                if (w_pos < w_fill) begin
                    o_rd_hit = 1'b1;
                end else begin
                    o_status = ST_RANGE;
                end
            end
            default: begin
                w_mode = CM_HOLD;
            end
        endcase
    end

    // Advance the fill count on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    assign o_mode      = i_accept ? w_mode : CM_HOLD;
    assign o_fill      = r_fill;
    assign o_next_fill = n_fill;

endmodule

// ===== src/bounded_list_engine_top.sv =====
// Bounded list engine: an ordered list of up to CAPACITY signed elements kept
// in a row of cells, element 0 at the front. Every operation, including a
// range append and a positional insert, is done in the cycle of its transfer,
// since all cells shift or load in parallel; the result is registered and
// appears on the output in the next cycle. One item per cycle is sustained;
// the input stalls only while a finished result waits on a stalled output.
// Depends on ble_pkg, ble_ctrl and ble_cell.
module bounded_list_engine_top
    import ble_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [OP_W-1:0]            i_op,
    input  logic signed [IN_VAL_W-1:0] i_item_value,
    input  logic [POS_W-1:0]           i_position,
    input  logic [POS_W-1:0]           i_count,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ST_W-1:0]            o_status,
    output logic [LEN_W-1:0]           o_length,
    output logic signed [RD_VAL_W-1:0] o_read_value
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    logic                          w_accept;
    t_cell_mode                    w_mode;
    logic [AW-1:0]                 w_at;
    logic signed [VALUE_WIDTH-1:0] w_value;
    logic [FW-1:0]                 w_fill;
    logic [FW-1:0]                 w_next_fill;
    t_status                       w_status;
    logic                          w_rd_hit;
    logic signed [VALUE_WIDTH-1:0] w_cell_q [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] w_rd_sel;

    logic                          r_out_valid;
    logic [ST_W-1:0]               r_status;
    logic [LEN_W-1:0]              r_length;
    logic signed [RD_VAL_W-1:0]    r_read_value;

    // Take a transfer unless a finished result is held on a stalled output
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Decode and count
    ble_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_op         (i_op),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .i_count      (i_count),
        .o_mode       (w_mode),
        .o_at         (w_at),
        .o_value      (w_value),
        .o_fill       (w_fill),
        .o_next_fill  (w_next_fill),
        .o_status     (w_status),
        .o_rd_hit     (w_rd_hit)
    );

    // Row of cells, each linked to its neighbors
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic signed [VALUE_WIDTH-1:0] w_left;
        logic signed [VALUE_WIDTH-1:0] w_right;

        if (j == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_q[j-1];
        end

        if (j == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_q[j];
        end else begin : g_mid_r
            assign w_right = w_cell_q[j+1];
        end

        ble_cell #(
            .CAPACITY    (CAPACITY),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CELL_INDEX  (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode),
            .i_at    (w_at),
            .i_fill  (w_fill),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_q     (w_cell_q[j])
        );
    end

    // Select the element for a read
    assign w_rd_sel = w_cell_q[AW'(i_position)];

    // Hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= w_status;
            r_length     <= LEN_W'(w_next_fill);
            r_read_value <= w_rd_hit ? RD_VAL_W'(w_rd_sel) : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_length     = r_length;
    assign o_read_value = r_read_value;

endmodule

// ===== test/bounded_list_engine_top_tb.sv =====
// Testbench for bounded_list_engine_top: directed table then shaped random traffic,
// every result checked against a typed result or one predicted from a shadow list.
// Depends on ble_pkg and the engine RTL only.
`timescale 1ns / 100ps

module bounded_list_engine_top_tb;
    import ble_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1424;
    localparam int CHOKE_AT     = 700;
    localparam int CHOKE_ITEMS  = 80;
    localparam int CHOKE_CYCLES = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_LIMIT   = 3000;
    localparam int MAX_REPORTS  = 10;

    // Random traffic shapes
    localparam int BIAS_GROW   = 0;
    localparam int BIAS_SHRINK = 1;
    localparam int BIAS_MIXED  = 2;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic signed [IN_VAL_W-1:0] value;
        logic [POS_W-1:0]           pos;
        logic [POS_W-1:0]           cnt;
    } t_list_req;

    typedef struct packed {
        logic [ST_W-1:0]            status;
        logic [LEN_W-1:0]           length;
        logic signed [RD_VAL_W-1:0] value;
    } t_list_res;

    typedef struct packed {
        t_list_req rq;
        logic      typed;
        t_list_res res;
    } t_dir_row;

    localparam int N_DIR = 26;

    // Directed table: typed results where they follow at a glance, else predicted
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{'{OP_POPFRONT,    32'sh0,          7'd0,  7'd0},  1'b1, '{ST_SHORT, 7'd0,  32'sh0}},
        '{'{OP_POPBACK,     32'sh0,          7'd0,  7'd0},  1'b1, '{ST_SHORT, 7'd0,  32'sh0}},
        '{'{OP_DROPSECOND,  32'sh0,          7'd0,  7'd0},  1'b1, '{ST_SHORT, 7'd0,  32'sh0}},
        '{'{OP_BEFORELAST,  32'sh5,          7'd0,  7'd0},  1'b1, '{ST_SHORT, 7'd0,  32'sh0}},
        '{'{OP_READ,        32'sh0,          7'd0,  7'd0},  1'b1, '{ST_RANGE, 7'd0,  32'sh0}},
        '{'{OP_DROPLAST,    32'sh0,          7'd0,  7'd0},  1'b1, '{ST_DONE,  7'd0,  32'sh0}},
        '{'{OP_APPENDRANGE, 32'sh0,          7'd0,  7'd0},  1'b1, '{ST_DONE,  7'd0,  32'sh0}},
        '{'{OP_PUSHBACK,    32'sh7FFF_FFFF,  7'd0,  7'd0},  1'b1, '{ST_DONE,  7'd1,  32'sh0}},
        '{'{OP_BEFORELAST,  32'sh5,          7'd0,  7'd0},  1'b1, '{ST_SHORT, 7'd1,  32'sh0}},
        '{'{OP_DROPSECOND,  32'sh0,          7'd0,  7'd0},  1'b1, '{ST_SHORT, 7'd1,  32'sh0}},
        '{'{OP_PUSHFRONT,   32'sh8000_0000,  7'd0,  7'd0},  1'b1, '{ST_DONE,  7'd2,  32'sh0}},
        '{'{OP_READ,        32'sh0,          7'd0,  7'd0},  1'b1,
          '{ST_DONE, 7'd2, 32'sh8000_0000}},
        '{'{OP_READ,        32'sh0,          7'd1,  7'd0},  1'b1,
          '{ST_DONE, 7'd2, 32'sh7FFF_FFFF}},
        '{'{OP_READ,        32'sh0,          7'd64, 7'd0},  1'b1, '{ST_RANGE, 7'd2,  32'sh0}},
        '{'{OP_INSERT,      32'shFFFF_FFFF,  7'd64, 7'd0},  1'b0, '0},
        '{'{OP_INSERT,      32'sh0,          7'd1,  7'd0},  1'b0, '0},
        '{'{OP_BEFORELAST,  32'sh3039,       7'd0,  7'd0},  1'b0, '0},
        '{'{OP_APPENDLEN,   32'sh0,          7'd0,  7'd0},  1'b0, '0},
        '{'{OP_DROPSECOND,  32'sh0,          7'd0,  7'd0},  1'b0, '0},
        '{'{4'hF,           32'sh1234_5678,  7'd3,  7'd3},  1'b0, '0},
        '{'{OP_APPENDRANGE, 32'sh0,          7'd0,  7'd64}, 1'b1, '{ST_FULL,  7'd64, 32'sh0}},
        '{'{OP_PUSHBACK,    32'sh1,          7'd0,  7'd0},  1'b1, '{ST_FULL,  7'd64, 32'sh0}},
        '{'{OP_INSERT,      32'sh2,          7'd3,  7'd0},  1'b1, '{ST_FULL,  7'd64, 32'sh0}},
        '{'{OP_BEFORELAST,  32'sh3,          7'd0,  7'd0},  1'b1, '{ST_FULL,  7'd64, 32'sh0}},
        '{'{OP_READ,        32'sh0,          7'd63, 7'd0},  1'b0, '0},
        '{'{OP_DROPLAST,    32'sh0,          7'd0,  7'd64}, 1'b1, '{ST_DONE,  7'd0,  32'sh0}}
    };

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_stall;
    logic [OP_W-1:0]            i_op         = '0;
    logic signed [IN_VAL_W-1:0] i_item_value = '0;
    logic [POS_W-1:0]           i_position   = '0;
    logic [POS_W-1:0]           i_count      = '0;
    logic                       o_out_valid;
    logic                       i_out_stall  = 1'b0;
    logic [ST_W-1:0]            o_status;
    logic [LEN_W-1:0]           o_length;
    logic signed [RD_VAL_W-1:0] o_read_value;

    // Shadow copy of the list, advanced at every input transfer
    logic signed [RD_VAL_W-1:0] shadow_cells [CAPACITY_DEF];
    int                         shadow_fill = 0;

    t_list_res awaited_outcomes [$];
    int        mismatch_count = 0;
    bit        choke_req      = 1'b0;

    bounded_list_engine_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .i_count      (i_count),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_length     (o_length),
        .o_read_value (o_read_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Insert into the shadow list; positions past the end append
    function automatic logic [ST_W-1:0] shadow_store(int at, logic signed [RD_VAL_W-1:0] v);
        int k;
        if (shadow_fill >= CAPACITY_DEF) return ST_FULL;
        if (at > shadow_fill) at = shadow_fill;
        for (k = shadow_fill; k > at; k--) shadow_cells[k] = shadow_cells[k-1];
        shadow_cells[at] = v;
        shadow_fill++;
        return ST_DONE;
    endfunction

    function automatic void shadow_remove(int at);
        int k;
        for (k = at; k < shadow_fill - 1; k++) shadow_cells[k] = shadow_cells[k+1];
        shadow_fill--;
    endfunction

    // Apply one operation to the shadow list and return the result it gives
    function automatic t_list_res perform_list_op(t_list_req rq);
        t_list_res res;
        int        k;
        res = '0;
        res.status = ST_DONE;
        case (rq.op)
            OP_PUSHBACK:  res.status = shadow_store(shadow_fill, rq.value);
            OP_PUSHFRONT: res.status = shadow_store(0, rq.value);
            OP_POPFRONT: begin
                if (shadow_fill == 0) res.status = ST_SHORT;
                else shadow_remove(0);
            end
            OP_POPBACK: begin
                if (shadow_fill == 0) res.status = ST_SHORT;
                else shadow_fill--;
            end
            OP_INSERT:    res.status = shadow_store(int'(rq.pos), rq.value);
            OP_DROPLAST:  shadow_fill = (rq.cnt >= shadow_fill) ? 0 : shadow_fill - rq.cnt;
            OP_DROPSECOND: begin
                if (shadow_fill <= 1) res.status = ST_SHORT;
                else shadow_remove(1);
            end
            OP_APPENDLEN: res.status = shadow_store(shadow_fill, shadow_fill);
            OP_APPENDRANGE: begin
                for (k = 1; k <= rq.cnt; k++) begin
                    if (shadow_store(shadow_fill, k) != ST_DONE) begin
                        res.status = ST_FULL;
                        break;
                    end
                end
            end
            OP_BEFORELAST: begin
                if (shadow_fill <= 1) res.status = ST_SHORT;
                else res.status = shadow_store(shadow_fill - 1, rq.value);
            end
            OP_READ: begin
                if (rq.pos < shadow_fill) res.value = shadow_cells[rq.pos];
                else res.status = ST_RANGE;
            end
            default: ;
        endcase
        res.length = LEN_W'(shadow_fill);
        return res;
    endfunction

    // Build one random item; the bias steers the list toward full or empty, or mixes ops
    function automatic t_list_req make_request(int bias);
        t_list_req rq;
        int        pick;
        pick   = $urandom_range(0, 99);
        rq.pos = POS_W'($urandom_range(0, CAPACITY_DEF));
        rq.cnt = POS_W'($urandom_range(0, CAPACITY_DEF));
        case ($urandom_range(0, 31))
            0:       rq.value = 32'sh8000_0000;
            1:       rq.value = 32'sh7FFF_FFFF;
            2:       rq.value = '0;
            3:       rq.value = '1;
            default: rq.value = $urandom;
        endcase
        if (bias == BIAS_GROW) begin
            if      (pick < 25) rq.op = OP_PUSHBACK;
            else if (pick < 45) rq.op = OP_PUSHFRONT;
            else if (pick < 60) rq.op = OP_INSERT;
            else if (pick < 68) rq.op = OP_APPENDRANGE;
            else if (pick < 73) rq.op = OP_APPENDLEN;
            else if (pick < 80) rq.op = OP_BEFORELAST;
            else if (pick < 92) rq.op = OP_READ;
            else if (pick < 95) rq.op = OP_POPFRONT;
            else if (pick < 97) rq.op = OP_POPBACK;
            else if (pick < 99) rq.op = OP_DROPSECOND;
            else                rq.op = OP_DROPLAST;
        end else if (bias == BIAS_SHRINK) begin
            if      (pick < 22) rq.op = OP_POPFRONT;
            else if (pick < 44) rq.op = OP_POPBACK;
            else if (pick < 54) rq.op = OP_DROPSECOND;
            else if (pick < 62) rq.op = OP_DROPLAST;
            else if (pick < 78) rq.op = OP_READ;
            else if (pick < 86) rq.op = OP_PUSHBACK;
            else if (pick < 93) rq.op = OP_INSERT;
            else                rq.op = OP_BEFORELAST;
        end else begin
            rq.op = OP_W'($urandom_range(OP_PUSHBACK, OP_READ));
        end
        // Keep most reads and half the inserts in range, and most drops and ranges short
        if (rq.op == OP_READ && shadow_fill > 0 && $urandom_range(0, 3) != 0)
            rq.pos = POS_W'($urandom_range(0, shadow_fill - 1));
        if (rq.op == OP_INSERT && $urandom_range(0, 1) == 0)
            rq.pos = POS_W'($urandom_range(0, shadow_fill));
        if (rq.op == OP_DROPLAST && $urandom_range(0, 3) != 0)
            rq.cnt = POS_W'($urandom_range(0, 4));
        if (rq.op == OP_APPENDRANGE && $urandom_range(0, 3) != 0)
            rq.cnt = POS_W'($urandom_range(0, 6));
        return rq;
    endfunction

    // Offer one item, hold it until the transfer, then record its outcome
    task automatic send_item(input t_list_req rq, input logic typed, input t_list_res typed_res);
        t_list_res predicted;
        i_in_valid   <= 1'b1;
        i_op         <= rq.op;
        i_item_value <= rq.value;
        i_position   <= rq.pos;
        i_count      <= rq.cnt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = perform_list_op(rq);
        awaited_outcomes.push_back(typed ? typed_res : predicted);
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
    endtask

    // Compare each output transfer with the oldest outcome waiting
    always @(posedge i_clk) begin : result_check
        t_list_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_outcomes.size() == 0) begin
                flag_mismatch("unexpected result, length", '0, 32'(o_length));
            end else begin
                want = awaited_outcomes.pop_front();
                if (o_status !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_length !== want.length)
                    flag_mismatch("length", 32'(want.length), 32'(o_length));
                if (o_read_value !== want.value)
                    flag_mismatch("read_value", want.value, o_read_value);
            end
        end
    end

    // Output stall patterns, plus one long hold-off when the sender asks
    initial begin : out_stall_gen
        int mode;
        int span;
        int period;
        int k;
        int choke_left;
        bit choke_served;
        choke_left   = 0;
        choke_served = 1'b0;
        forever begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(4, 80);
            period = $urandom_range(2, 5);
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                if (choke_req && !choke_served) begin
                    choke_served = 1'b1;
                    choke_left   = CHOKE_CYCLES;
                end
                if (choke_left > 0) begin
                    choke_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    case (mode)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 1) == 1);
                        2:       i_out_stall <= ((k % period) == 0);
                        default: i_out_stall <= ($urandom_range(0, 9) < 8);
                    endcase
                end
            end
        end
    end

    // End the run when no transfer happens on either side for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle = 0;
            else idle++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int        n;
        int        burst_left;
        int        phase_left;
        int        bias;
        int        gap;
        bit        in_choke;
        t_list_res none;
        none       = '0;
        burst_left = 0;
        phase_left = 0;
        bias       = BIAS_MIXED;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[r]) send_item(DIR_ROWS[r].rq, DIR_ROWS[r].typed, DIR_ROWS[r].res);

        // Random part: phases of growth, shrinkage and mixed ops, sent in bursts
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                bias       = $urandom_range(BIAS_GROW, BIAS_MIXED);
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            if (n == CHOKE_AT) choke_req = 1'b1;
            in_choke = (n >= CHOKE_AT) && (n < CHOKE_AT + CHOKE_ITEMS);
            if (burst_left == 0 && !in_choke) begin
                burst_left = $urandom_range(1, 30);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            if (burst_left > 0) burst_left--;
            send_item(make_request(bias), 1'b0, none);
        end
        i_in_valid <= 1'b0;

        // Drain, then watch a little longer for stray results
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
